/* src/cbta_pkg.sv */
package cbta_pkg;

  // Field and state widths
  localparam int TempW   = 12;
  localparam int CntW    = 8;
  localparam int SumW    = 21;
  localparam int DivCntW = $clog2(SumW);
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);

  // Register reset values
  localparam logic [CntW-1:0] CoarseReset = 8'd10;
  localparam logic [CntW-1:0] FineReset   = 8'd20;

  // Register indexes
  localparam logic [1:0] CfgCoarse = 2'd0;
  localparam logic [1:0] CfgFine   = 2'd1;

  typedef enum logic {
    KindCoarse = 1'b0,
    KindFine   = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StCDiv = 5'b00010,
    StCOut = 5'b00100,
    StFDiv = 5'b01000,
    StFOut = 5'b10000
  } back_state_e;

  // One coarse average to be worked out by the back end
  typedef struct packed {
    logic signed [SumW-1:0]  sum;
    logic        [CntW-1:0]  count;
    logic signed [TempW-1:0] outdoor;
  } job_t;

  // Divider status seen by the back end
  typedef struct packed {
    logic                    busy;
    logic signed [TempW-1:0] quot;
  } div_status_t;

endpackage

/* src/cbta_front.sv */
module cbta_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [cbta_pkg::TempW-1:0]       indoor_temp_i,
  input  logic signed [cbta_pkg::TempW-1:0]       outdoor_temp_i,
  input  logic        [cbta_pkg::CntW-1:0]        coarse_length_i,
  input  logic                                    full_i,
  output logic                                    push_o,
  output cbta_pkg::job_t                          job_o
);

  logic signed [cbta_pkg::SumW-1:0] coarse_sum_q, coarse_sum_d;
  logic        [cbta_pkg::CntW-1:0] coarse_count_q, coarse_count_d;
  logic signed [cbta_pkg::SumW-1:0] sum_new;
  logic        [cbta_pkg::CntW-1:0] cnt_new;
  logic                             accept;
  logic                             trig;

  // Take an item whenever the queue has room
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Accumulate and decide whether this item closes a coarse block
  assign sum_new = coarse_sum_q +
                   {{(cbta_pkg::SumW-cbta_pkg::TempW){indoor_temp_i[cbta_pkg::TempW-1]}},
                    indoor_temp_i};
  assign cnt_new = coarse_count_q + cbta_pkg::CntW'(1);
  assign trig    = !(cnt_new < coarse_length_i);

  assign push_o        = accept && trig;
  assign job_o.sum     = sum_new;
  assign job_o.count   = cnt_new;
  assign job_o.outdoor = outdoor_temp_i;

  // Clear the block on a trigger, else keep summing
  always_comb begin
    coarse_sum_d   = coarse_sum_q;
    coarse_count_d = coarse_count_q;
    if (accept) begin
      if (trig) begin
        coarse_sum_d   = '0;
        coarse_count_d = '0;
      end else begin
        coarse_sum_d   = sum_new;
        coarse_count_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_sum_q   <= '0;
      coarse_count_q <= '0;
    end else begin
      coarse_sum_q   <= coarse_sum_d;
      coarse_count_q <= coarse_count_d;
    end
  end

endmodule

/* src/cbta_fifo.sv */
module cbta_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbta_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output cbta_pkg::job_t job_o
);

  cbta_pkg::job_t                    mem_q [cbta_pkg::QDepth];
  logic [cbta_pkg::QPtrW-1:0]        wr_ptr_q;
  logic [cbta_pkg::QPtrW-1:0]        rd_ptr_q;
  logic [cbta_pkg::QPtrW:0]          fill_q;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (fill_q == (cbta_pkg::QPtrW+1)'(cbta_pkg::QDepth));
  assign valid_o = (fill_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Store items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + cbta_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + cbta_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (cbta_pkg::QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (cbta_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

/* src/cbta_div.sv */
module cbta_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [cbta_pkg::SumW-1:0]   dividend_i,
  input  logic        [cbta_pkg::CntW-1:0]   divisor_i,
  output cbta_pkg::div_status_t              status_o
);

  logic                          busy_q;
  logic [cbta_pkg::DivCntW-1:0]  cnt_q;
  logic [cbta_pkg::SumW-1:0]     dq_q, dq_d;
  logic [cbta_pkg::CntW-1:0]     rem_q, rem_d;
  logic [cbta_pkg::CntW-1:0]     div_q;
  logic                          neg_q;
  logic [cbta_pkg::SumW-1:0]     mag;
  logic [cbta_pkg::CntW:0]       trial;
  logic [cbta_pkg::CntW:0]       diff;
  logic [cbta_pkg::TempW-1:0]    mag_lo;

  // Divide magnitudes, fix the sign at the end (truncation toward zero)
  assign mag = dividend_i[cbta_pkg::SumW-1] ? cbta_pkg::SumW'(-dividend_i)
                                            : cbta_pkg::SumW'(dividend_i);

  // One restoring step per cycle: quotient bits shift in behind the dividend
  always_comb begin
    trial = {rem_q, dq_q[cbta_pkg::SumW-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[cbta_pkg::CntW-1:0];
      dq_d  = {dq_q[cbta_pkg::SumW-2:0], 1'b1};
    end else begin
      rem_d = trial[cbta_pkg::CntW-1:0];
      dq_d  = {dq_q[cbta_pkg::SumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[cbta_pkg::SumW-1];
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == cbta_pkg::DivCntW'(cbta_pkg::SumW-1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + cbta_pkg::DivCntW'(1);
    end
  end

  assign mag_lo          = dq_q[cbta_pkg::TempW-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.quot   = neg_q ? -mag_lo : mag_lo;

endmodule

/* src/cbta_back.sv */
module cbta_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [cbta_pkg::CntW-1:0]    fine_length_i,
  input  logic                                job_valid_i,
  input  cbta_pkg::job_t                      job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic signed [cbta_pkg::TempW-1:0]   average_o,
  output logic signed [cbta_pkg::TempW-1:0]   outdoor_now_o,
  output logic                                last_o
);

  cbta_pkg::back_state_e             state_q, state_d;
  cbta_pkg::div_status_t             div_st;
  logic signed [cbta_pkg::SumW-1:0]  fine_sum_q;
  logic        [cbta_pkg::CntW-1:0]  fine_count_q;
  logic signed [cbta_pkg::SumW-1:0]  fine_sum_new;
  logic        [cbta_pkg::CntW-1:0]  fine_cnt_new;
  logic                              fine_trig;
  logic                              fine_pend_q;
  logic signed [cbta_pkg::TempW-1:0] outdoor_q;
  cbta_pkg::kind_e                   kind_q;
  logic signed [cbta_pkg::TempW-1:0] avg_q;
  logic                              last_q;
  logic                              div_start;
  logic signed [cbta_pkg::SumW-1:0]  div_dividend;
  logic        [cbta_pkg::CntW-1:0]  div_divisor;
  logic                              coarse_done;
  logic                              fine_done;

  cbta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_st)
  );

  // Fold the new coarse average into the fine block
  assign fine_sum_new = fine_sum_q +
                        {{(cbta_pkg::SumW-cbta_pkg::TempW){div_st.quot[cbta_pkg::TempW-1]}},
                         div_st.quot};
  assign fine_cnt_new = fine_count_q + cbta_pkg::CntW'(1);
  assign fine_trig    = !(fine_cnt_new < fine_length_i);

  assign coarse_done = (state_q == cbta_pkg::StCDiv) && !div_st.busy;
  assign fine_done   = (state_q == cbta_pkg::StFDiv) && !div_st.busy;

  // Start the divider on a new job or on a closed fine block
  assign pop_o     = (state_q == cbta_pkg::StIdle) && job_valid_i;
  always_comb begin
    div_start    = 1'b0;
    div_dividend = job_i.sum;
    div_divisor  = job_i.count;
    if (pop_o) begin
      div_start = 1'b1;
    end else if (coarse_done && fine_trig) begin
      div_start    = 1'b1;
      div_dividend = fine_sum_new;
      div_divisor  = fine_cnt_new;
    end
  end

  // Sequence: coarse divide, coarse result, optional fine divide and result
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbta_pkg::StIdle: if (job_valid_i) state_d = cbta_pkg::StCDiv;
      cbta_pkg::StCDiv: if (!div_st.busy) state_d = cbta_pkg::StCOut;
      cbta_pkg::StCOut: begin
        if (out_ready_i) state_d = fine_pend_q ? cbta_pkg::StFDiv : cbta_pkg::StIdle;
      end
      cbta_pkg::StFDiv: if (!div_st.busy) state_d = cbta_pkg::StFOut;
      cbta_pkg::StFOut: if (out_ready_i) state_d = cbta_pkg::StIdle;
      default:          state_d = cbta_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cbta_pkg::StIdle;
      fine_sum_q   <= '0;
      fine_count_q <= '0;
      fine_pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (coarse_done) begin
        fine_pend_q <= fine_trig;
        if (fine_trig) begin
          fine_sum_q   <= '0;
          fine_count_q <= '0;
        end else begin
          fine_sum_q   <= fine_sum_new;
          fine_count_q <= fine_cnt_new;
        end
      end
    end
  end

  // Hold the result fields for the receiver
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      outdoor_q <= job_i.outdoor;
    end
    if (coarse_done) begin
      kind_q <= cbta_pkg::KindCoarse;
      avg_q  <= div_st.quot;
      last_q <= !fine_trig;
    end else if (fine_done) begin
      kind_q <= cbta_pkg::KindFine;
      avg_q  <= div_st.quot;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o   = (state_q == cbta_pkg::StCOut) || (state_q == cbta_pkg::StFOut);
  assign kind_o        = kind_q;
  assign average_o     = avg_q;
  assign outdoor_now_o = outdoor_q;
  assign last_o        = last_q;

endmodule

/* src/cascaded_block_temperature_averager.sv */
// Cascaded block temperature averager.
// Input channel (in_valid_i/in_ready_o) takes one tick with an indoor and an
// outdoor temperature in 1/16 degree. Indoor values are summed; every
// coarse_length ticks a coarse average (truncated toward zero) leaves on the
// output channel (out_valid_o/out_ready_i) with kind 0 and the outdoor value
// of that tick. Every fine_length coarse averages a fine average follows as a
// second item with kind 1. last_o marks the final item caused by a tick.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 coarse_length, 1 fine_length); other indexes are ignored.
// A coarse result passes the queue, the 21-step shared bit-serial divider
// and the output register once the closing tick is taken; a fine result
// follows when the fine divide is done and the coarse one is taken. The
// back end takes a new closing tick only from idle, after the results of
// the last one are taken. Ticks that close no block are taken one per
// cycle while the two-entry queue has room.
// Reset clears all sums and counts and loads lengths 10 and 20. A stalled
// receiver holds the result; the queue fills and then in_ready_o drops.
module cascaded_block_temperature_averager (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cbta_pkg::TempW-1:0]  indoor_temp_i,
  input  logic signed [cbta_pkg::TempW-1:0]  outdoor_temp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               kind_o,
  output logic signed [cbta_pkg::TempW-1:0]  average_o,
  output logic signed [cbta_pkg::TempW-1:0]  outdoor_now_o,
  output logic                               last_o,
  input  logic                               cfg_we_i,
  input  logic        [1:0]                  cfg_index_i,
  input  logic        [cbta_pkg::CntW-1:0]   cfg_data_i
);

  logic [cbta_pkg::CntW-1:0] coarse_length_q;
  logic [cbta_pkg::CntW-1:0] fine_length_q;
  logic                      push;
  logic                      full;
  logic                      job_valid;
  logic                      pop;
  cbta_pkg::job_t            job_in;
  cbta_pkg::job_t            job_out;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_length_q <= cbta_pkg::CoarseReset;
      fine_length_q   <= cbta_pkg::FineReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cbta_pkg::CfgCoarse: coarse_length_q <= cfg_data_i;
        cbta_pkg::CfgFine:   fine_length_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbta_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .indoor_temp_i   (indoor_temp_i),
    .outdoor_temp_i  (outdoor_temp_i),
    .coarse_length_i (coarse_length_q),
    .full_i          (full),
    .push_o          (push),
    .job_o           (job_in)
  );

  cbta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  cbta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fine_length_i (fine_length_q),
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .average_o     (average_o),
    .outdoor_now_o (outdoor_now_o),
    .last_o        (last_o)
  );

endmodule
